// ===== rtl/core/lfu_pkg.sv =====
// lfu_pkg: shared constants for the LFU cache table.
// No dependencies.
package lfu_pkg;
	localparam int unsigned CAP_W           = 5;
	localparam int unsigned KEY_W           = 32;
	localparam int unsigned DATA_W          = 32;
	localparam int unsigned CNT_W           = 32;
	localparam int unsigned DEF_MAX_ENTRIES = 16;

	localparam logic [CAP_W-1:0]  CAP_RESET  = 5'd16;
	localparam logic [DATA_W-1:0] MISS_VALUE = '1;
	localparam logic [DATA_W-1:0] PUT_VALUE  = '0;
	localparam logic [CNT_W-1:0]  CNT_FIRST  = 32'd1;
	localparam logic [CNT_W-1:0]  CNT_MAX    = '1;

	localparam logic KIND_GET = 1'b0;
	localparam logic KIND_PUT = 1'b1;
endpackage

// ===== rtl/core/lfu_ifs.sv =====
// lfu_ifs: valid/ready channels of the LFU cache table (request, response, config).
// Depends on lfu_pkg.
interface lfu_req_if;
	import lfu_pkg::*;
	logic              valid;
	logic              ready;
	logic              kind;
	logic [KEY_W-1:0]  key;
	logic [DATA_W-1:0] put_value;
	modport source (output valid, kind, key, put_value, input ready);
	modport sink   (input valid, kind, key, put_value, output ready);
endinterface

interface lfu_rsp_if;
	import lfu_pkg::*;
	logic              valid;
	logic              ready;
	logic              hit;
	logic [DATA_W-1:0] read_value;
	modport source (output valid, hit, read_value, input ready);
	modport sink   (input valid, hit, read_value, output ready);
endinterface

interface lfu_cfg_if;
	import lfu_pkg::*;
	logic             valid;
	logic             ready;
	logic [CAP_W-1:0] data;
	modport source (output valid, data, input ready);
	modport sink   (input valid, data, output ready);
endinterface

// ===== rtl/core/lfu_mem.sv =====
// lfu_mem: single-port-write, registered-read entry memory.
// No package dependencies.
module lfu_mem #(
	parameter int unsigned DEPTH = 16,
	parameter int unsigned AW    = 4,
	parameter int unsigned W     = 100
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [W-1:0]  wdata,
	input  logic [AW-1:0] raddr,
	output logic [W-1:0]  rdata
);
	logic [W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// ===== rtl/core/lfu_cache_table.sv =====
// LFU cache table: key/value cache, least-frequently-used replacement with
// least-recently-used tie break. Entries live in one memory read one per cycle.
// Each word takes one scan pass over all MAX_ENTRIES slots and a decision step;
// a word that changes the table adds a read-modify-write pass over all slots.
// A get miss or a put that changes nothing skips that pass. The response is
// posted from ST_DONE, and the next word is taken only after that, later while
// the response stalls. The memory's single read port sets the pace.
// Depends on lfu_pkg, lfu_ifs, lfu_mem.
module lfu_cache_table #(
	parameter int unsigned MAX_ENTRIES = lfu_pkg::DEF_MAX_ENTRIES
) (
	input  logic      clk,
	input  logic      arst_n,
	lfu_cfg_if.sink   cfg,
	lfu_req_if.sink   req,
	lfu_rsp_if.source rsp
);
	import lfu_pkg::*;

	localparam int unsigned IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int unsigned FW = $clog2(MAX_ENTRIES + 1);
	localparam logic [IW-1:0] LAST = IW'(MAX_ENTRIES - 1);

	typedef struct packed {
		logic [KEY_W-1:0]  key;
		logic [DATA_W-1:0] value;
		logic [CNT_W-1:0]  count;
		logic [IW-1:0]     rank;
	} entry_t;

	localparam int unsigned W_ENT = $bits(entry_t);

	typedef enum logic [2:0] {ST_IDLE, ST_SCAN, ST_DECIDE, ST_UPD, ST_DONE} state_t;
	typedef enum logic [1:0] {MD_HIT, MD_EVICT, MD_INS} mode_t;

	state_t            state_q;
	mode_t             mode_q;
	logic [CAP_W-1:0]  cap_q;
	logic [MAX_ENTRIES-1:0] valid_q;
	logic              kind_q;
	logic [KEY_W-1:0]  key_q;
	logic [DATA_W-1:0] val_q;
	logic [IW-1:0]     addr_q;
	logic              issue_q;
	logic              rd_s1;
	logic [IW-1:0]     idx_s1;
	logic [FW-1:0]     fill_q;
	logic              found_q;
	logic [IW-1:0]     found_idx_q;
	logic [DATA_W-1:0] found_val_q;
	logic [IW-1:0]     found_rank_q;
	logic              vic_q;
	logic [IW-1:0]     vic_idx_q;
	logic [CNT_W-1:0]  vic_cnt_q;
	logic [IW-1:0]     vic_rank_q;
	logic              free_q;
	logic [IW-1:0]     free_idx_q;
	logic [IW-1:0]     tgt_q;
	logic [IW-1:0]     ref_rank_q;
	logic              out_valid_q;
	logic              out_hit_q;
	logic [DATA_W-1:0] out_val_q;
	logic              res_hit_q;
	logic [DATA_W-1:0] res_val_q;

	entry_t            rd_ent;
	entry_t            wr_ent;
	logic              we;
	logic [31:0]       cap_eff;
	logic [31:0]       fill_ext;
	logic [W_ENT-1:0]  rdata;

	assign rd_ent = entry_t'(rdata);

	lfu_mem #(.DEPTH(MAX_ENTRIES), .AW(IW), .W(W_ENT)) u_mem (
		.clk   (clk),
		.we    (we),
		.waddr (idx_s1),
		.wdata (wr_ent),
		.raddr (addr_q),
		.rdata (rdata)
	);

	assign cfg.ready = 1'b1;
	assign req.ready = (state_q == ST_IDLE);
	assign rsp.valid = out_valid_q;
	assign rsp.hit = out_hit_q;
	assign rsp.read_value = out_val_q;

	assign cap_eff = ({{(32-CAP_W){1'b0}}, cap_q} > 32'(MAX_ENTRIES)) ?
		32'(MAX_ENTRIES) : {{(32-CAP_W){1'b0}}, cap_q};
	assign fill_ext = 32'(fill_q);

	always_comb begin
		wr_ent = rd_ent;
		we = 1'b0;
		if (state_q == ST_UPD && rd_s1) begin
			if (idx_s1 == tgt_q) begin
				we = 1'b1;
				wr_ent.rank = '0;
				if (mode_q == MD_HIT) begin
					if (kind_q == KIND_PUT) begin
						wr_ent.value = val_q;
					end
					if (rd_ent.count != CNT_MAX) begin
						wr_ent.count = rd_ent.count + CNT_FIRST;
					end
				end else begin
					wr_ent.key = key_q;
					wr_ent.value = val_q;
					wr_ent.count = CNT_FIRST;
				end
			end else if (valid_q[idx_s1]) begin
				we = 1'b1;
				unique case (mode_q)
					MD_HIT: begin
						if (rd_ent.rank < ref_rank_q) begin
							wr_ent.rank = rd_ent.rank + 1'b1;
						end
					end
					MD_EVICT: begin
						if (rd_ent.rank < ref_rank_q) begin
							wr_ent.rank = rd_ent.rank + 1'b1;
						end
					end
					MD_INS: wr_ent.rank = rd_ent.rank + 1'b1;
					default: wr_ent.rank = rd_ent.rank;
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			mode_q <= MD_HIT;
			cap_q <= CAP_RESET;
			valid_q <= '0;
			issue_q <= 1'b0;
			rd_s1 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg.valid) begin
				cap_q <= cfg.data;
			end
			if (rsp.ready && state_q != ST_DONE) begin
				out_valid_q <= 1'b0;
			end
			if (issue_q) begin
				rd_s1 <= 1'b1;
				idx_s1 <= addr_q;
				if (addr_q == LAST) begin
					issue_q <= 1'b0;
				end else begin
					addr_q <= addr_q + 1'b1;
				end
			end else begin
				rd_s1 <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (req.valid) begin
						kind_q <= req.kind;
						key_q <= req.key;
						val_q <= req.put_value;
						addr_q <= '0;
						issue_q <= 1'b1;
						fill_q <= '0;
						found_q <= 1'b0;
						vic_q <= 1'b0;
						free_q <= 1'b0;
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (rd_s1) begin
						if (valid_q[idx_s1]) begin
							fill_q <= fill_q + 1'b1;
							if (rd_ent.key == key_q) begin
								found_q <= 1'b1;
								found_idx_q <= idx_s1;
								found_val_q <= rd_ent.value;
								found_rank_q <= rd_ent.rank;
							end
							if (!vic_q || rd_ent.count < vic_cnt_q ||
							    (rd_ent.count == vic_cnt_q && rd_ent.rank > vic_rank_q)) begin
								vic_q <= 1'b1;
								vic_idx_q <= idx_s1;
								vic_cnt_q <= rd_ent.count;
								vic_rank_q <= rd_ent.rank;
							end
						end else if (!free_q) begin
							free_q <= 1'b1;
							free_idx_q <= idx_s1;
						end
						if (idx_s1 == LAST) begin
							state_q <= ST_DECIDE;
						end
					end
				end
				ST_DECIDE: begin
					res_hit_q <= found_q;
					if (found_q) begin
						res_val_q <= (kind_q == KIND_GET) ? found_val_q : PUT_VALUE;
						mode_q <= MD_HIT;
						tgt_q <= found_idx_q;
						ref_rank_q <= found_rank_q;
						addr_q <= '0;
						issue_q <= 1'b1;
						state_q <= ST_UPD;
					end else if (kind_q == KIND_GET) begin
						res_val_q <= MISS_VALUE;
						state_q <= ST_DONE;
					end else begin
						res_val_q <= PUT_VALUE;
						if (cap_eff != 32'd0 && fill_ext >= cap_eff && vic_q) begin
							mode_q <= MD_EVICT;
							tgt_q <= vic_idx_q;
							ref_rank_q <= vic_rank_q;
							addr_q <= '0;
							issue_q <= 1'b1;
							state_q <= ST_UPD;
						end else if (cap_eff != 32'd0 && free_q) begin
							mode_q <= MD_INS;
							tgt_q <= free_idx_q;
							valid_q[free_idx_q] <= 1'b1;
							addr_q <= '0;
							issue_q <= 1'b1;
							state_q <= ST_UPD;
						end else begin
							state_q <= ST_DONE;
						end
					end
				end
				ST_UPD: begin
					if (rd_s1 && idx_s1 == LAST) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (!out_valid_q || rsp.ready) begin
						out_valid_q <= 1'b1;
						out_hit_q <= res_hit_q;
						out_val_q <= res_val_q;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule
